// ===== hw/rtl/lrupr_pkg.sv =====
// Shared constants, types and state codes for the LRU page replacement block.
// Used by both RTL modules and both bench modules; depends on nothing.
package lrupr_pkg;

   localparam int FRAME_COUNT      = 16;
   localparam int PAGE_BITS        = 16;
   localparam int IDX_BITS         = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int CNT_BITS         = $clog2(FRAME_COUNT + 1);
   localparam int LIMIT_BITS       = 5;
   localparam int LIMIT_RESET      = 16;
   localparam int CMP_BITS         = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;
   localparam int FAULT_BITS       = 16;
   localparam int PAGE_FIELD_BITS  = 16;
   localparam int REQ_DATA_BITS    = ((PAGE_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS   = 2 + PAGE_FIELD_BITS + FAULT_BITS;
   localparam int RSP_DATA_BITS    = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS     = RSP_DATA_BITS - RSP_FIELD_BITS;

   typedef logic [PAGE_BITS-1:0]  page_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [FAULT_BITS-1:0] fault_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // one frame as seen by the scan unit in one cycle
   typedef struct packed {
      logic     valid;
      page_type page;
      idx_type  rank;
      idx_type  idx;
   } scan_entry_type;

   // accumulated outcome of a full pass over the frames
   typedef struct packed {
      logic     found;
      idx_type  found_idx;
      idx_type  found_rank;
      cnt_type  count;
      logic     oldest_any;
      idx_type  oldest_idx;
      idx_type  oldest_rank;
      page_type oldest_page;
      logic     free_any;
      idx_type  free_idx;
   } scan_result_type;

   // result word, last field in the lowest bits
   typedef struct packed {
      logic [RSP_PAD_BITS-1:0]    pad;
      logic [FAULT_BITS-1:0]      fault_count;
      logic [PAGE_FIELD_BITS-1:0] victim_page;
      logic                       victim_valid;
      logic                       hit;
   } rsp_word_type;

endpackage

// ===== hw/rtl/lru_page_replacement.sv =====
// LRU page replacement top level: frame store, sequencer and result register.
// Depends on lrupr_pkg and lrupr_scan.
//
// Usage:
//  - req channel: one word per page reference. tdata[15:0] is the page
//    referenced, tuser is start_new (empty all frames and zero the fault
//    count first).
//  - rsp channel: one word per reference with hit, victim_valid, victim_page
//    and the fault count after this reference (saturates at 65535).
//  - csr port: csr_wr_en/csr_wr_data set frame_limit (0 acts as 1, values
//    above 16 act as 16). Write it only while the block is idle.
//  - Sequence: from acceptance the block scans the frames, one per cycle,
//    through the shared compare unit looking for a match, the LRU frame
//    and the first free frame, then updates ranks and the frame store
//    together with the result register. req_tready is high only while
//    idle, so a new word is taken only once the last one has finished.
//  - Stall: the result sits in an output register; the next reference is
//    accepted and scanned while it waits, and only the update step holds
//    until rsp_tready frees the register.
//  - Reset (synchronous): all frames empty, fault count zero, frame_limit 16,
//    no result pending.
module lru_page_replacement (
   input  logic                                clock,
   input  logic                                reset,
   // input words
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lrupr_pkg::REQ_DATA_BITS-1:0] req_tdata,   // [15:0] page
   input  logic                                req_tuser,   // [0] start_new
   // result words
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] hit, [1] victim_valid, [17:2] victim_page, [33:18] fault_count, rest 0
   output logic [lrupr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // frame_limit register
   input  logic                                csr_wr_en,
   input  logic [lrupr_pkg::LIMIT_BITS-1:0]    csr_wr_data
);
   import lrupr_pkg::*;

   state_type                 state_ff, state_in;
   idx_type                   scan_idx_ff, scan_idx_in;
   logic [LIMIT_BITS-1:0]     limit_ff, limit_in;
   logic [FRAME_COUNT-1:0]    valid_ff, valid_in;
   page_type                  page_ff [FRAME_COUNT];
   page_type                  page_in [FRAME_COUNT];
   idx_type                   rank_ff [FRAME_COUNT];
   idx_type                   rank_in [FRAME_COUNT];
   page_type                  key_ff, key_in;
   fault_type                 faults_ff, faults_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_data_ff, rsp_data_in;

   logic                      req_accept;
   logic                      upd_go;
   logic                      scan_last;
   logic                      evict;
   idx_type                   slot;
   logic [CMP_BITS-1:0]       lim_eff;
   fault_type                 faults_new;
   logic                      frame_keep;
   scan_entry_type            entry;
   scan_result_type           res;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign scan_last  = (scan_idx_ff == IDX_BITS'(FRAME_COUNT - 1));
   assign upd_go     = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_tready);

   // one frame a cycle into the compare unit
   assign entry.valid = valid_ff[scan_idx_ff];
   assign entry.page  = page_ff[scan_idx_ff];
   assign entry.rank  = rank_ff[scan_idx_ff];
   assign entry.idx   = scan_idx_ff;

   lrupr_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_clear (req_accept),
      .scan_step  (state_ff == ST_SCAN),
      .key        (key_ff),
      .entry      (entry),
      .result     (res)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (upd_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // replacement decision from the finished scan
   always_comb begin
      if (limit_ff == '0) begin
         lim_eff = CMP_BITS'(1);
      end else if (CMP_BITS'(limit_ff) > CMP_BITS'(FRAME_COUNT)) begin
         lim_eff = CMP_BITS'(FRAME_COUNT);
      end else begin
         lim_eff = CMP_BITS'(limit_ff);
      end
      evict = !res.found && res.oldest_any && (CMP_BITS'(res.count) >= lim_eff);
      // lowest free frame, counting the one just vacated by the eviction
      if (evict && !(res.free_any && (res.free_idx < res.oldest_idx))) begin
         slot = res.oldest_idx;
      end else begin
         slot = res.free_idx;
      end
      if (!res.found && (faults_ff != '1)) begin
         faults_new = faults_ff + 1'b1;
      end else begin
         faults_new = faults_ff;
      end
   end

   // frame store, ranks and fault count
   always_comb begin
      valid_in   = valid_ff;
      page_in    = page_ff;
      rank_in    = rank_ff;
      key_in     = key_ff;
      faults_in  = faults_ff;
      limit_in   = limit_ff;
      frame_keep = 1'b0;
      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end
      if (req_accept) begin
         key_in = page_type'(req_tdata[PAGE_FIELD_BITS-1:0]);
         if (req_tuser) begin
            valid_in  = '0;
            faults_in = '0;
         end
      end
      if (upd_go) begin
         faults_in = faults_new;
         if (res.found) begin
            for (int i = 0; i < FRAME_COUNT; i++) begin
               if (valid_ff[i] && (rank_ff[i] < res.found_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[res.found_idx] = '0;
         end else begin
            for (int i = 0; i < FRAME_COUNT; i++) begin
               frame_keep  = valid_ff[i] && !(evict && (IDX_BITS'(i) == res.oldest_idx));
               valid_in[i] = frame_keep;
               if (frame_keep) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            valid_in[slot] = 1'b1;
            page_in[slot]  = key_ff;
            rank_in[slot]  = '0;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (upd_go) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.pad          = '0;
         rsp_data_in.hit          = res.found;
         rsp_data_in.victim_valid = evict;
         rsp_data_in.victim_page  = evict ? PAGE_FIELD_BITS'(res.oldest_page) : '0;
         rsp_data_in.fault_count  = faults_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         limit_ff     <= LIMIT_BITS'(LIMIT_RESET);
         valid_ff     <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         limit_ff     <= limit_in;
         valid_ff     <= valid_in;
         faults_ff    <= faults_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      rank_ff     <= rank_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // every accepted word starts a scan at frame zero
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN) && (scan_idx_ff == '0))
      else $error("scan did not start after accept");

   // a fault without eviction must have found a free frame
   a_free_on_fill: assert property (@(posedge clock) disable iff (reset)
      (upd_go && !res.found && !evict) |-> res.free_any)
      else $error("no free frame for a new page");

   // a hit never reports a victim
   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.hit) |-> !rsp_data_ff.victim_valid)
      else $error("hit carries a victim");

   // a fault leaves a nonzero fault count behind
   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      (upd_go && !res.found) |=> (faults_ff != '0) && rsp_valid_ff)
      else $error("fault not counted");

endmodule

// ===== hw/rtl/lrupr_scan.sv =====
// Shared compare unit: takes one frame per cycle and accumulates match,
// resident count, LRU frame and first free frame. Depends on lrupr_pkg.
module lrupr_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        scan_clear,
   input  logic                        scan_step,
   input  lrupr_pkg::page_type         key,
   input  lrupr_pkg::scan_entry_type   entry,
   output lrupr_pkg::scan_result_type  result
);
   import lrupr_pkg::*;

   scan_result_type res_ff, res_in;

   always_comb begin
      res_in = res_ff;
      if (scan_clear) begin
         res_in = '0;
      end else if (scan_step) begin
         if (entry.valid) begin
            res_in.count = res_ff.count + 1'b1;
            if (entry.page == key) begin
               res_in.found      = 1'b1;
               res_in.found_idx  = entry.idx;
               res_in.found_rank = entry.rank;
            end
            // strict compare keeps the lowest frame on a tie
            if (!res_ff.oldest_any || (entry.rank > res_ff.oldest_rank)) begin
               res_in.oldest_any  = 1'b1;
               res_in.oldest_idx  = entry.idx;
               res_in.oldest_rank = entry.rank;
               res_in.oldest_page = entry.page;
            end
         end else if (!res_ff.free_any) begin
            res_in.free_any = 1'b1;
            res_in.free_idx = entry.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

   // count can only reach the number of frames scanned
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      res_ff.count <= CNT_BITS'(FRAME_COUNT))
      else $error("scan count exceeds frame count");

   // a match always comes from a resident frame, so count is nonzero
   a_found_count: assert property (@(posedge clock) disable iff (reset)
      res_ff.found |-> (res_ff.count != '0) && res_ff.oldest_any)
      else $error("match recorded without a resident frame");

   // the first free frame, once taken, is never replaced in the pass
   a_free_hold: assert property (@(posedge clock) disable iff (reset)
      (res_ff.free_any && !scan_clear) |=> res_ff.free_any &&
         (res_ff.free_idx == $past(res_ff.free_idx)))
      else $error("first free frame changed during scan");

endmodule

// ===== bench/lrupr_checker.sv =====
// Predicting monitor for the LRU page replacement block: keeps its own frame
// table, fault count and frame limit, and scores every result word in order.
// Depends on lrupr_pkg.
module lrupr_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [lrupr_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                                req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [lrupr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [lrupr_pkg::LIMIT_BITS-1:0]    csr_wr_data,
   output int                                  error_count,
   output int                                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import lrupr_pkg::*;

   logic                  frame_used [FRAME_COUNT];
   page_type              frame_pg   [FRAME_COUNT];
   idx_type               frame_age  [FRAME_COUNT];   // 0 = most recently used
   fault_type             fault_tally;
   logic [LIMIT_BITS-1:0] limit_reg;
   rsp_word_type          pending_outcomes [$];

   function automatic void clear_frames();
      for (int i = 0; i < FRAME_COUNT; i++) begin
         frame_used[i] = 1'b0;
      end
      fault_tally = '0;
   endfunction

   // one page reference against the frame table; returns the word it yields
   function automatic rsp_word_type apply_reference(page_type pg, logic fresh);
      rsp_word_type outcome;
      int           hit_at;
      int           lru_at;
      int           free_at;
      int           resident;
      int           cap;
      idx_type      hit_age;
      outcome  = '0;
      if (fresh) clear_frames();
      cap      = (limit_reg == 0) ? 1 : (limit_reg > FRAME_COUNT) ? FRAME_COUNT : int'(limit_reg);
      hit_at   = -1;
      resident = 0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
         if (frame_used[i]) begin
            resident++;
            if (frame_pg[i] == pg) hit_at = i;
         end
      end
      if (hit_at >= 0) begin
         hit_age     = frame_age[hit_at];
         outcome.hit = 1'b1;
         for (int i = 0; i < FRAME_COUNT; i++) begin
            if (frame_used[i] && frame_age[i] < hit_age) frame_age[i]++;
         end
         frame_age[hit_at] = '0;
      end else begin
         if (fault_tally != '1) fault_tally++;
         // at or over the limit: drop the oldest before loading
         if (resident >= cap) begin
            lru_at = -1;
            for (int i = 0; i < FRAME_COUNT; i++) begin
               if (frame_used[i] && (lru_at < 0 || frame_age[i] > frame_age[lru_at]))
                  lru_at = i;
            end
            outcome.victim_valid = 1'b1;
            outcome.victim_page  = frame_pg[lru_at];
            frame_used[lru_at]   = 1'b0;
         end
         for (int i = 0; i < FRAME_COUNT; i++) begin
            if (frame_used[i]) frame_age[i]++;
         end
         free_at = -1;
         for (int i = 0; i < FRAME_COUNT; i++) begin
            if (!frame_used[i] && free_at < 0) free_at = i;
         end
         frame_used[free_at] = 1'b1;
         frame_pg[free_at]   = pg;
         frame_age[free_at]  = '0;
      end
      outcome.fault_count = fault_tally;
      return outcome;
   endfunction

   function automatic void note_error(string what);
      error_count++;
      if (error_count <= 10) $display("%0t ns: %s", $time, what);
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         clear_frames();
         limit_reg = LIMIT_BITS'(LIMIT_RESET);
         pending_outcomes.delete();
      end else begin
         if (csr_wr_en) limit_reg = csr_wr_data;
         if (req_tvalid && req_tready)
            pending_outcomes.push_back(apply_reference(req_tdata[PAGE_BITS-1:0], req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            if (pending_outcomes.size() == 0) begin
               note_error($sformatf("unexpected rsp word %h", rsp_tdata));
            end else begin
               want = pending_outcomes.pop_front();
               if (got.hit !== want.hit || got.victim_valid !== want.victim_valid ||
                   got.victim_page !== want.victim_page ||
                   got.fault_count !== want.fault_count)
                  note_error($sformatf(
                     "rsp word: exp hit=%0b vv=%0b vp=%h fc=%0d, got hit=%0b vv=%0b vp=%h fc=%0d",
                     want.hit, want.victim_valid, want.victim_page, want.fault_count,
                     got.hit, got.victim_valid, got.victim_page, got.fault_count));
            end
         end
      end
      outstanding = pending_outcomes.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the LRU page replacement bench: clock, reset, request and config
// stimulus, result backpressure and the verdict.
// Depends on lrupr_pkg, lru_page_replacement and lrupr_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lrupr_pkg::*;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;    // [15:0] page
   logic                     req_tuser   = 1'b0;  // [0] start_new
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;           // [0] hit, [1] victim_valid,
                                                  // [17:2] victim_page, [33:18] fault_count
   logic                     csr_wr_en   = 1'b0;
   logic [LIMIT_BITS-1:0]    csr_wr_data = '0;

   int send_idle_pct = 30;   // chance that the sender pauses before a word
   int recv_idle_pct = 47;   // chance per cycle that the receiver stalls
   int error_count;
   int outstanding;

   always #5 clock = ~clock;

   lru_page_replacement dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lrupr_checker lru_watch (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // receiver backpressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // One request word. tvalid stays up from the previous word unless this
   // one starts with a pause, so it never gets two updates in one step.
   // Pauses are drawn at random in length so they land on every phase of the scan.
   task automatic send_ref(input page_type pg, input logic fresh);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 36)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(pg);
      req_tuser  <= fresh;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // frame_limit is only written with the block drained: every word
   // makes exactly one result, so no result owed means idle
   task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // A reference string over a small hot set of the frame budget plus zero to
   // four pages, so hits, faults and evictions all keep happening. A few words
   // are stray full-range pages; a few of those also restart the string.
   task automatic run_reference_string(input int cap, input int length);
      page_type hot [24];
      int       hot_n;
      int       roll;
      page_type pg;
      hot_n = cap + $urandom_range(0, 4);
      for (int i = 0; i < hot_n; i++) hot[i] = page_type'($urandom);
      for (int k = 0; k < length; k++) begin
         roll = $urandom_range(99);
         if (roll < 85) pg = hot[$urandom_range(hot_n - 1)];
         else           pg = page_type'($urandom);
         send_ref(pg, k == 0 || roll >= 97);
      end
   endtask

   initial begin : stimulus
      logic [LIMIT_BITS-1:0] lim;
      int                    cap;
      int                    drawn;
      int                    len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // reset limit is 16; open a string and hit the page extremes
      send_ref(16'h0000, 1'b1);
      send_ref(16'hFFFF, 1'b0);
      send_ref(16'h0000, 1'b0);              // hit: 0x0000 now newest, 0xFFFF oldest
      for (int p = 1; p <= 14; p++)          // fill all sixteen frames
         send_ref(page_type'(p << 4), 1'b0);
      send_ref(16'h8001, 1'b0);              // full: 0xFFFF goes
      send_ref(16'h0000, 1'b0);              // still resident
      // limit dropped under the resident count: every fault evicts, none dropped
      write_limit(5'd2);
      send_ref(16'h4242, 1'b0);
      send_ref(16'h0010, 1'b0);
      // start on a resident page: emptied first, so it faults
      send_ref(16'h0000, 1'b1);
      // zero behaves as one frame
      write_limit(5'd0);
      send_ref(16'h00FF, 1'b0);
      send_ref(16'h00FF, 1'b0);
      // above the frame count behaves as sixteen
      write_limit(5'd31);
      send_ref(16'h7777, 1'b0);

      // ---- random strings, three backpressure regimes ----
      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin send_idle_pct = 30; recv_idle_pct = 47; end
            1: begin send_idle_pct = 47; recv_idle_pct = 30; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         drawn = 0;
         while (drawn < 150) begin
            case ($urandom_range(5))
               0: lim = 5'd0;
               1: lim = 5'd1;
               2: lim = 5'd16;
               3: lim = 5'd31;
               default: lim = LIMIT_BITS'($urandom_range(2, 15));
            endcase
            write_limit(lim);
            cap = (lim == 0) ? 1 : (lim > FRAME_COUNT) ? FRAME_COUNT : int'(lim);
            repeat ($urandom_range(1, 3)) begin
               len = $urandom_range(8, 40);
               run_reference_string(cap, len);
               drawn += len;
            end
         end
      end

      // drain, then keep watching for any stray word
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // a full run, even with the longest pauses, ends well before this timeout
   initial begin : watchdog
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_scan.sv
hw/rtl/lru_page_replacement.sv
bench/lrupr_checker.sv
bench/testbench.sv
